// File: hdl/cdtd_pkg.sv
// ----------------------------------------------------------------------------
// cdtd_pkg
// Shared types and codes of the compact font DICT token decoder.
// ----------------------------------------------------------------------------
package cdtd_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 4;

  // Byte classes, as seen by a parser that is idle.
  localparam logic [3:0] CLS_OP      = 4'd0;  // operator 0-11, 13-27, 31
  localparam logic [3:0] CLS_ESC     = 4'd1;  // escape 12
  localparam logic [3:0] CLS_SHORT   = 4'd2;  // 28, 16-bit integer follows
  localparam logic [3:0] CLS_LONG    = 4'd3;  // 29, 32-bit integer follows
  localparam logic [3:0] CLS_REAL    = 4'd4;  // 30, packed decimal follows
  localparam logic [3:0] CLS_POS2    = 4'd5;  // 247-250
  localparam logic [3:0] CLS_NEG2    = 4'd6;  // 251-254
  localparam logic [3:0] CLS_INVALID = 4'd7;  // 255
  localparam logic [3:0] CLS_SMALL   = 4'd8;  // 32-246, one-byte integer

  // Token kinds.
  localparam logic [2:0] KIND_OP      = 3'd0;
  localparam logic [2:0] KIND_ESC_OP  = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_REAL    = 3'd3;
  localparam logic [2:0] KIND_INVALID = 3'd4;

  localparam logic [7:0] BYTE_INVALID = 8'd255;
  localparam logic [3:0] NIB_END      = 4'hf;

  typedef struct packed {
    logic       start;
    logic [7:0] data_byte;
    logic [3:0] cls;
  } item_t;

  typedef struct packed {
    logic               real_done;
    logic [1:0]         nibbles_valid;
    logic [3:0]         nibble_low;
    logic [3:0]         nibble_high;
    logic signed [31:0] int_value;
    logic [7:0]         op_code;
    logic [2:0]         token_kind;
  } token_t;

endpackage

// File: hdl/cff_dict_token_decoder.sv
// ----------------------------------------------------------------------------
// cff_dict_token_decoder
// Decodes a compact font DICT byte stream into operator and operand tokens.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, with the output taken each cycle.
// A token's last byte waits in the classifier queue, then the parser output
// register holds the token until it is taken; an output stall keeps bytes
// waiting in the queue.
// The queue between classifier and parser holds FIFO_DEPTH bytes.
// Reset clears the parser to idle and empties the queue.
module cff_dict_token_decoder #(
  parameter int FIFO_DEPTH = cdtd_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] dict_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] op_code, [39:8] int_value, [43:40] nibble_high, [47:44] nibble_low,
  // [49:48] nibbles_valid, [50] real_done, [55:51] zero
  output logic [55:0] m_tdata,
  output logic [2:0]  m_tuser    // [2:0] token_kind
);

  logic             push, q_ready, q_valid, pop;
  cdtd_pkg::item_t  wr_item, rd_item;
  cdtd_pkg::token_t token;

  cdtd_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .data_byte  (s_tdata),
    .dict_start (s_tuser[0]),
    .push       (push),
    .item       (wr_item),
    .q_ready    (q_ready)
  );

  cdtd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (wr_item),
    .not_full  (q_ready),
    .pop       (pop),
    .rd_item   (rd_item),
    .not_empty (q_valid)
  );

  cdtd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (rd_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .token    (token)
  );

  assign m_tuser = token.token_kind;
  assign m_tdata = {5'd0, token.real_done, token.nibbles_valid, token.nibble_low,
                    token.nibble_high, token.int_value, token.op_code};

endmodule

// File: hdl/cdtd_front.sv
// ----------------------------------------------------------------------------
// cdtd_front
// Accepts stream bytes and tags each with its lead-byte class.
// ----------------------------------------------------------------------------
module cdtd_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      data_byte,
  input  logic            dict_start,
  output logic            push,
  output cdtd_pkg::item_t item,
  input  logic            q_ready
);

  logic [3:0] cls;

  always_comb begin
    if (data_byte == 8'd12) begin
      cls = cdtd_pkg::CLS_ESC;
    end else if (data_byte == 8'd28) begin
      cls = cdtd_pkg::CLS_SHORT;
    end else if (data_byte == 8'd29) begin
      cls = cdtd_pkg::CLS_LONG;
    end else if (data_byte == 8'd30) begin
      cls = cdtd_pkg::CLS_REAL;
    end else if (data_byte <= 8'd27 || data_byte == 8'd31) begin
      cls = cdtd_pkg::CLS_OP;
    end else if (data_byte >= 8'd247 && data_byte <= 8'd250) begin
      cls = cdtd_pkg::CLS_POS2;
    end else if (data_byte >= 8'd251 && data_byte <= 8'd254) begin
      cls = cdtd_pkg::CLS_NEG2;
    end else if (data_byte == cdtd_pkg::BYTE_INVALID) begin
      cls = cdtd_pkg::CLS_INVALID;
    end else begin
      cls = cdtd_pkg::CLS_SMALL;
    end
  end

  assign s_tready       = q_ready;
  assign push           = s_tvalid && q_ready;
  assign item.start     = dict_start;
  assign item.data_byte = data_byte;
  assign item.cls       = cls;

endmodule

// File: hdl/cdtd_fifo.sv
// ----------------------------------------------------------------------------
// cdtd_fifo
// Short register queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module cdtd_fifo #(
  parameter int DEPTH = cdtd_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cdtd_pkg::item_t wr_item,
  output logic            not_full,
  input  logic            pop,
  output cdtd_pkg::item_t rd_item,
  output logic            not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cdtd_pkg::item_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign not_full  = count != (AW+1)'(DEPTH);
  assign not_empty = count != '0;
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/cdtd_back.sv
// ----------------------------------------------------------------------------
// cdtd_back
// Parser state machine; gathers operand bytes and holds the output token.
// ----------------------------------------------------------------------------
module cdtd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cdtd_pkg::item_t   q_item,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output cdtd_pkg::token_t  token
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_ESC   = 3'd1;
  localparam logic [2:0] MODE_SHORT = 3'd2;
  localparam logic [2:0] MODE_LONG  = 3'd3;
  localparam logic [2:0] MODE_POS2  = 3'd4;
  localparam logic [2:0] MODE_NEG2  = 3'd5;
  localparam logic [2:0] MODE_REAL  = 3'd6;

  logic [2:0]  mode, mode_next, cur_mode;
  logic [2:0]  bytes_left, bytes_left_next, left_dec;
  logic [31:0] acc, acc_next, acc_shift;
  logic [1:0]  lead_ofs, lead_ofs_next;
  logic        emit;
  cdtd_pkg::token_t tok;
  logic [7:0]  b;
  logic [3:0]  hi, lo;
  logic [10:0] two_byte;

  assign pop       = q_valid && (!m_tvalid || m_tready);
  assign b         = q_item.data_byte;
  assign hi        = b[7:4];
  assign lo        = b[3:0];
  assign cur_mode  = q_item.start ? MODE_IDLE : mode;
  assign acc_shift = {acc[23:0], b};
  assign left_dec  = bytes_left - 3'd1;
  assign two_byte  = 11'd108 + {1'b0, lead_ofs, b};

  always_comb begin
    mode_next       = mode;
    bytes_left_next = bytes_left;
    acc_next        = acc;
    lead_ofs_next   = lead_ofs;
    emit            = 1'b0;
    tok             = '0;
    unique case (cur_mode)
      MODE_ESC: begin
        mode_next      = MODE_IDLE;
        emit           = 1'b1;
        tok.token_kind = cdtd_pkg::KIND_ESC_OP;
        tok.op_code    = b;
      end
      MODE_SHORT, MODE_LONG: begin
        acc_next        = acc_shift;
        bytes_left_next = left_dec;
        tok.token_kind  = cdtd_pkg::KIND_INT;
        if (cur_mode == MODE_SHORT) begin
          tok.int_value = {{16{acc_shift[15]}}, acc_shift[15:0]};
        end else begin
          tok.int_value = acc_shift;
        end
        if (left_dec == 3'd0) begin
          mode_next = MODE_IDLE;
          emit      = 1'b1;
        end
      end
      MODE_POS2: begin
        mode_next      = MODE_IDLE;
        emit           = 1'b1;
        tok.token_kind = cdtd_pkg::KIND_INT;
        tok.int_value  = {21'd0, two_byte};
      end
      MODE_NEG2: begin
        mode_next      = MODE_IDLE;
        emit           = 1'b1;
        tok.token_kind = cdtd_pkg::KIND_INT;
        tok.int_value  = 32'd0 - {21'd0, two_byte};
      end
      MODE_REAL: begin
        emit            = 1'b1;
        tok.token_kind  = cdtd_pkg::KIND_REAL;
        tok.nibble_high = hi;
        tok.nibble_low  = lo;
        if (hi == cdtd_pkg::NIB_END) begin
          mode_next     = MODE_IDLE;
          tok.real_done = 1'b1;
        end else if (lo == cdtd_pkg::NIB_END) begin
          mode_next         = MODE_IDLE;
          tok.nibbles_valid = 2'd1;
          tok.real_done     = 1'b1;
        end else begin
          tok.nibbles_valid = 2'd2;
        end
      end
      default: begin
        // Idle, and the unused mode code behaves the same.
        mode_next = MODE_IDLE;
        unique case (q_item.cls)
          cdtd_pkg::CLS_ESC: begin
            mode_next = MODE_ESC;
          end
          cdtd_pkg::CLS_SHORT: begin
            mode_next       = MODE_SHORT;
            bytes_left_next = 3'd2;
            acc_next        = '0;
          end
          cdtd_pkg::CLS_LONG: begin
            mode_next       = MODE_LONG;
            bytes_left_next = 3'd4;
            acc_next        = '0;
          end
          cdtd_pkg::CLS_REAL: begin
            mode_next = MODE_REAL;
          end
          cdtd_pkg::CLS_OP: begin
            emit           = 1'b1;
            tok.token_kind = cdtd_pkg::KIND_OP;
            tok.op_code    = b;
          end
          cdtd_pkg::CLS_POS2, cdtd_pkg::CLS_NEG2: begin
            // Both lead ranges map to an offset of the low two bits plus one.
            mode_next     = (q_item.cls == cdtd_pkg::CLS_POS2) ? MODE_POS2 : MODE_NEG2;
            lead_ofs_next = b[1:0] + 2'd1;
          end
          cdtd_pkg::CLS_INVALID: begin
            emit           = 1'b1;
            tok.token_kind = cdtd_pkg::KIND_INVALID;
            tok.op_code    = cdtd_pkg::BYTE_INVALID;
          end
          default: begin
            emit           = 1'b1;
            tok.token_kind = cdtd_pkg::KIND_INT;
            tok.int_value  = {24'd0, b} - 32'd139;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      bytes_left <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (pop) begin
        mode       <= mode_next;
        bytes_left <= bytes_left_next;
        m_tvalid   <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc      <= acc_next;
      lead_ofs <= lead_ofs_next;
      if (emit) begin
        token <= tok;
      end
    end
  end

endmodule

// File: tb/cdtd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdtd_tb_pkg
// Byte codes of the DICT stream shared by the stimulus and the token checker.
// ----------------------------------------------------------------------------
package cdtd_tb_pkg;

  localparam logic [7:0] BYTE_OP_FIRST    = 8'd0;
  localparam logic [7:0] BYTE_ESCAPE      = 8'd12;
  localparam logic [7:0] BYTE_OP_MAX_LOW  = 8'd27;
  localparam logic [7:0] BYTE_INT16       = 8'd28;
  localparam logic [7:0] BYTE_INT32       = 8'd29;
  localparam logic [7:0] BYTE_REAL        = 8'd30;
  localparam logic [7:0] BYTE_OP_HIGH     = 8'd31;
  localparam logic [7:0] BYTE_SMALL_FIRST = 8'd32;
  localparam logic [7:0] BYTE_SMALL_LAST  = 8'd246;
  localparam logic [7:0] BYTE_POS2_FIRST  = 8'd247;
  localparam logic [7:0] BYTE_POS2_LAST   = 8'd250;
  localparam logic [7:0] BYTE_NEG2_FIRST  = 8'd251;
  localparam logic [7:0] BYTE_NEG2_LAST   = 8'd254;

  localparam logic [31:0] SMALL_BIAS    = 32'd139;
  localparam logic [31:0] TWO_BYTE_BIAS = 32'd108;

endpackage

// File: tb/cdtd_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdtd_token_checker
// Watches both stream channels of the DICT token decoder, decodes every
// accepted byte with its own parser model and compares each output transfer
// field by field with the oldest token still due.
// ----------------------------------------------------------------------------
module cdtd_token_checker
  import cdtd_pkg::*;
  import cdtd_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          fail_count,
  output int          due_count,
  output int          tokens_seen,
  output int          int_tokens,
  output int          real_tokens
);

  localparam int PRINT_LIMIT = 30;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ESC, ST_INT16, ST_INT32, ST_POS2, ST_NEG2, ST_REAL
  } parse_state_e;

  parse_state_e pstate;
  logic [2:0]   bytes_due;
  logic [31:0]  acc;
  logic [7:0]   lead;

  token_t tokens_due[$];
  token_t new_token;
  logic   has_token;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < PRINT_LIMIT)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Parser model: one byte in, at most one token out.
  task automatic decode_byte(input logic start, input logic [7:0] b,
                             output logic hit, output token_t tok);
    logic [7:0] idx;
    logic [3:0] hn;
    logic [3:0] ln;
    tok = '0;
    hit = 1'b1;
    hn = b[7:4];
    ln = b[3:0];
    if (start) begin
      pstate = ST_IDLE;
      bytes_due = '0;
    end
    case (pstate)
      ST_ESC: begin
        pstate = ST_IDLE;
        tok.token_kind = KIND_ESC_OP;
        tok.op_code = b;
      end
      ST_INT16, ST_INT32: begin
        acc = {acc[23:0], b};
        bytes_due = bytes_due - 3'd1;
        if (bytes_due != 0) begin
          hit = 1'b0;
        end else begin
          tok.token_kind = KIND_INT;
          if (pstate == ST_INT16)
            tok.int_value = {{16{acc[15]}}, acc[15:0]};
          else
            tok.int_value = acc;
          pstate = ST_IDLE;
        end
      end
      ST_POS2: begin
        idx = lead - BYTE_POS2_FIRST;
        pstate = ST_IDLE;
        tok.token_kind = KIND_INT;
        tok.int_value = TWO_BYTE_BIAS + {22'd0, idx[1:0], b};
      end
      ST_NEG2: begin
        idx = lead - BYTE_NEG2_FIRST;
        pstate = ST_IDLE;
        tok.token_kind = KIND_INT;
        tok.int_value = -(TWO_BYTE_BIAS + {22'd0, idx[1:0], b});
      end
      ST_REAL: begin
        tok.token_kind = KIND_REAL;
        tok.nibble_high = hn;
        tok.nibble_low = ln;
        if (hn == NIB_END) begin
          pstate = ST_IDLE;
          tok.real_done = 1'b1;
        end else if (ln == NIB_END) begin
          pstate = ST_IDLE;
          tok.nibbles_valid = 2'd1;
          tok.real_done = 1'b1;
        end else begin
          tok.nibbles_valid = 2'd2;
        end
      end
      default: begin
        pstate = ST_IDLE;
        if (b == BYTE_ESCAPE) begin
          pstate = ST_ESC;
          hit = 1'b0;
        end else if (b == BYTE_INT16 || b == BYTE_INT32) begin
          pstate = (b == BYTE_INT16) ? ST_INT16 : ST_INT32;
          bytes_due = (b == BYTE_INT16) ? 3'd2 : 3'd4;
          acc = '0;
          hit = 1'b0;
        end else if (b == BYTE_REAL) begin
          pstate = ST_REAL;
          hit = 1'b0;
        end else if (b <= BYTE_OP_MAX_LOW || b == BYTE_OP_HIGH) begin
          tok.token_kind = KIND_OP;
          tok.op_code = b;
        end else if (b >= BYTE_POS2_FIRST && b <= BYTE_NEG2_LAST) begin
          lead = b;
          pstate = (b <= BYTE_POS2_LAST) ? ST_POS2 : ST_NEG2;
          hit = 1'b0;
        end else if (b == BYTE_INVALID) begin
          tok.token_kind = KIND_INVALID;
          tok.op_code = BYTE_INVALID;
        end else begin
          tok.token_kind = KIND_INT;
          tok.int_value = {24'd0, b} - SMALL_BIAS;
        end
      end
    endcase
  endtask

  task automatic check_token();
    token_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch("token_kind of a token nobody expected", m_tuser, 0);
      return;
    end
    want = tokens_due.pop_front();
    tokens_seen++;
    if (want.token_kind == KIND_INT) int_tokens++;
    if (want.token_kind == KIND_REAL) real_tokens++;
    if (m_tuser !== want.token_kind)
      report_mismatch("token_kind", m_tuser, want.token_kind);
    if (m_tdata[7:0] !== want.op_code)
      report_mismatch("op_code", m_tdata[7:0], want.op_code);
    if (m_tdata[39:8] !== want.int_value)
      report_mismatch("int_value", $signed(m_tdata[39:8]), want.int_value);
    if (m_tdata[43:40] !== want.nibble_high)
      report_mismatch("nibble_high", m_tdata[43:40], want.nibble_high);
    if (m_tdata[47:44] !== want.nibble_low)
      report_mismatch("nibble_low", m_tdata[47:44], want.nibble_low);
    if (m_tdata[49:48] !== want.nibbles_valid)
      report_mismatch("nibbles_valid", m_tdata[49:48], want.nibbles_valid);
    if (m_tdata[50] !== want.real_done)
      report_mismatch("real_done", m_tdata[50], want.real_done);
    if (m_tdata[55:51] !== 5'd0)
      report_mismatch("tdata padding", m_tdata[55:51], 0);
  endtask

  // The output side is handled first; a token can never leave in the same
  // cycle as the byte that caused it.
  always @(posedge clk) begin
    if (rst) begin
      pstate = ST_IDLE;
      bytes_due = '0;
      acc = '0;
      lead = '0;
      tokens_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_token();
      if (s_tvalid && s_tready) begin
        decode_byte(s_tuser[0], s_tdata, has_token, new_token);
        if (has_token) tokens_due.push_back(new_token);
      end
    end
    due_count <= tokens_due.size();
  end

endmodule

// File: tb/tb_cff_dict_token_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cff_dict_token_decoder
// Feeds the DICT token decoder a directed set of edge-case byte sequences and
// then a long run of randomly built tokens mixed with noise and cut-off
// sequences, with random stalls on both stream sides and one long output
// hold-off. A separate checker predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_cff_dict_token_decoder;
  import cdtd_pkg::*;
  import cdtd_tb_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_BYTES   = 1250;
  localparam int PRESSURE_AT    = 600;
  localparam int SHUFFLE_EVERY  = 150;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {
    TOK_OP, TOK_ESC, TOK_SMALL, TOK_POS2, TOK_NEG2, TOK_INT16, TOK_INT32,
    TOK_REAL, TOK_INVALID, TOK_NOISE
  } stim_token_e;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;

  int fail_count;
  int due_count;
  int tokens_seen;
  int int_tokens;
  int real_tokens;

  int bytes_sent;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_off_req;

  cff_dict_token_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  cdtd_token_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .due_count   (due_count),
    .tokens_seen (tokens_seen),
    .int_tokens  (int_tokens),
    .real_tokens (real_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Offers one byte and returns at the edge where its transfer happens, or after a random gap that follows it.
  task automatic send_byte(input logic start, input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_token();
    stim_token_e kind;
    int          r;
    int          n;
    logic [7:0]  b;
    logic [3:0]  hn;
    logic [3:0]  ln;
    logic        start;
    r = $urandom_range(0, 99);
    if (r < 14) kind = TOK_OP;
    else if (r < 22) kind = TOK_ESC;
    else if (r < 38) kind = TOK_SMALL;
    else if (r < 48) kind = TOK_POS2;
    else if (r < 58) kind = TOK_NEG2;
    else if (r < 68) kind = TOK_INT16;
    else if (r < 78) kind = TOK_INT32;
    else if (r < 92) kind = TOK_REAL;
    else if (r < 95) kind = TOK_INVALID;
    else kind = TOK_NOISE;
    start = ($urandom_range(0, 15) == 0);
    case (kind)
      TOK_OP: begin
        b = 8'($urandom_range(BYTE_OP_FIRST, BYTE_OP_MAX_LOW));
        if (b == BYTE_ESCAPE) b = BYTE_OP_HIGH;
        send_byte(start, b);
      end
      TOK_ESC: begin
        send_byte(start, BYTE_ESCAPE);
        send_byte(1'b0, 8'($urandom_range(0, 255)));
      end
      TOK_SMALL: send_byte(start, 8'($urandom_range(BYTE_SMALL_FIRST, BYTE_SMALL_LAST)));
      TOK_POS2, TOK_NEG2: begin
        b = (kind == TOK_POS2) ? BYTE_POS2_FIRST : BYTE_NEG2_FIRST;
        b = b + 8'($urandom_range(0, 3));
        send_byte(start, b);
        send_byte(1'b0, 8'($urandom_range(0, 255)));
      end
      TOK_INT16, TOK_INT32: begin
        send_byte(start, (kind == TOK_INT16) ? BYTE_INT16 : BYTE_INT32);
        repeat ((kind == TOK_INT16) ? 2 : 4) send_byte(1'b0, 8'($urandom_range(0, 255)));
      end
      TOK_REAL: begin
        send_byte(start, BYTE_REAL);
        n = $urandom_range(0, 5);
        repeat (n) begin
          hn = 4'($urandom_range(0, 14));
          ln = 4'($urandom_range(0, 14));
          send_byte(1'b0, {hn, ln});
        end
        // The terminator sits in either half of the last byte.
        if ($urandom_range(0, 1) == 0) begin
          ln = 4'($urandom_range(0, 15));
          send_byte(1'b0, {NIB_END, ln});
        end else begin
          hn = 4'($urandom_range(0, 14));
          send_byte(1'b0, {hn, NIB_END});
        end
      end
      TOK_INVALID: send_byte(start, BYTE_INVALID);
      default: begin
        // Arbitrary bytes, often with dict_start set, to break sequences.
        repeat ($urandom_range(1, 3))
          send_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Output side: random stalls, plus one long hold-off when requested.
  initial begin : sink
    int  n;
    bit  hold_taken;
    hold_taken = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d tokens still due",
                 WATCHDOG_LIMIT, due_count);
        $display("tb_cff_dict_token_decoder NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int next_shuffle;
    bit pressure_done;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_off_req <= 1'b0;
    bytes_sent = 0;
    pressure_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every token kind, both terminator positions
    // and a cut-off integer discarded by dict_start.
    send_byte(1'b0, BYTE_OP_FIRST);
    send_byte(1'b0, BYTE_OP_HIGH);
    send_byte(1'b0, BYTE_ESCAPE);
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, BYTE_SMALL_LAST);
    send_byte(1'b0, BYTE_SMALL_FIRST);
    send_byte(1'b0, BYTE_POS2_FIRST);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, BYTE_NEG2_LAST);
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, BYTE_INT16);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, BYTE_INT32);
    send_byte(1'b0, 8'h7f);
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, BYTE_REAL);
    send_byte(1'b0, 8'he1);
    send_byte(1'b0, 8'hd5);
    send_byte(1'b0, 8'h0f);
    send_byte(1'b0, BYTE_REAL);
    send_byte(1'b0, 8'hf7);
    send_byte(1'b0, BYTE_INVALID);
    send_byte(1'b0, BYTE_INT32);
    send_byte(1'b0, 8'h12);
    send_byte(1'b1, BYTE_OP_MAX_LOW);

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    next_shuffle = bytes_sent + SHUFFLE_EVERY;
    while (bytes_sent < RANDOM_BYTES) begin
      if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
        // Keep offering bytes back to back while the output is held off,
        // so the internal queue fills and the input side stalls.
        pressure_done = 1'b1;
        tx_gaps = 1'b0;
        hold_off_req <= 1'b1;
        repeat (16) send_token();
      end
      if (bytes_sent >= next_shuffle) begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_gaps = ($urandom_range(0, 2) != 0);
        next_shuffle += SHUFFLE_EVERY;
      end
      send_token();
    end
    s_tvalid <= 1'b0;

    // The count of due tokens is a registered copy of the checker's queue size.
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d stream bytes and %0d decoded tokens (%0d integers, %0d real pairs).",
             bytes_sent, tokens_seen, int_tokens, real_tokens);
    $display("It included directed edge cases, noise, dict_start cuts and a long output hold-off.");
    if (fail_count == 0) begin
      $display("tb_cff_dict_token_decoder OK");
    end else begin
      $display("tb_cff_dict_token_decoder NOT OK");
    end
    $finish;
  end

endmodule

// File: cff_dict_token_decoder.f
hdl/cdtd_pkg.sv
hdl/cdtd_front.sv
hdl/cdtd_fifo.sv
hdl/cdtd_back.sv
hdl/cff_dict_token_decoder.sv
tb/cdtd_tb_pkg.sv
tb/cdtd_token_checker.sv
tb/tb_cff_dict_token_decoder.sv
